[hw/rtl/vdla_pkg.sv]
// ============================================================================
// vdla_pkg
// Shared types and constants for the voxel dose / LET accumulator.
// ============================================================================
`default_nettype none

package vdla_pkg;

    localparam int VOXEL_COUNT_DEF = 4096;
    localparam int CLASS_COUNT_DEF = 10;

    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [11:0] voxel_index;
        logic [4:0]  particle_class;
        logic [31:0] energy_deposit;
        logic [31:0] let_weight;
    } in_item_t;

    typedef struct packed {
        logic [47:0] energy_total;
        logic [47:0] let_total;
        logic [31:0] let_dose_averaged;
        logic [31:0] event_total;
        logic [31:0] dose_value;
    } out_item_t;

    // Read-out sums handed to the finishing math
    typedef struct packed {
        logic        zero;
        logic [47:0] energy;
        logic [47:0] let_sum;
        logic [31:0] events;
    } rd_item_t;

endpackage

`default_nettype wire

[hw/rtl/vdla_front.sv]
// ============================================================================
// vdla_front
// Accepts items, classifies them and forms a command queue entry.
// ============================================================================
`default_nettype none

module vdla_front #(
    parameter int VOXEL_COUNT = vdla_pkg::VOXEL_COUNT_DEF,
    parameter int CLASS_COUNT = vdla_pkg::CLASS_COUNT_DEF,
    parameter int AW          = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire vdla_pkg::in_item_t in_item,
    // command queue toward back end
    output logic                 q_valid,
    input  wire                  q_pop,
    output logic                 q_rd,
    output logic                 q_zero,
    output logic                 q_two,
    output logic [AW-1:0]        q_addr_a,
    output logic [AW-1:0]        q_addr_b,
    output logic [31:0]          q_e,
    output logic [31:0]          q_l
);

    localparam int QD = 2;

    typedef struct packed {
        logic          rd;
        logic          zero;
        logic          two;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic [31:0]   e;
        logic [31:0]   l;
    } cmd_t;

    cmd_t     q_reg [QD];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    cmd_t       c;
    logic       vox_ok, slot_ok, acc, do_push;
    logic signed [5:0] slot;
    logic [AW-1:0] base;

    // Classify the incoming item
    always_comb
    begin
        vox_ok  = {20'd0, in_item.voxel_index} < 32'(VOXEL_COUNT);
        slot    = $signed({in_item.particle_class[4], in_item.particle_class}) + 6'sd1;
        slot_ok = (slot >= 0) && (slot < 6'(CLASS_COUNT));
        base    = AW'(in_item.voxel_index) * AW'(CLASS_COUNT);
        c.rd    = (in_item.cmd == vdla_pkg::CMD_READ);
        c.zero  = !(vox_ok && slot_ok);
        c.two   = slot_ok && (slot != 6'sd1);
        c.a     = base + AW'(1);
        c.b     = base + AW'(slot[4:0]);
        c.e     = in_item.energy_deposit;
        c.l     = in_item.let_weight;
        acc     = c.rd || (vox_ok && in_item.energy_deposit != 32'd0
                           && in_item.let_weight != 32'd0);
        if (c.rd)
            c.a = c.b;
    end

    assign full    = (cnt_reg == 2'(QD));
    assign do_push = push && !full && acc;
    assign q_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !(q_pop && q_valid))
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && q_pop && q_valid)
            cnt_next = cnt_reg - 2'd1;
    end

    // Advance the queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wp_reg <= !wp_reg;
            if (q_pop && q_valid)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= c;
    end

    assign q_rd     = q_reg[rp_reg].rd;
    assign q_zero   = q_reg[rp_reg].zero;
    assign q_two    = q_reg[rp_reg].two;
    assign q_addr_a = q_reg[rp_reg].a;
    assign q_addr_b = q_reg[rp_reg].b;
    assign q_e      = q_reg[rp_reg].e;
    assign q_l      = q_reg[rp_reg].l;

endmodule

`default_nettype wire

[hw/rtl/vdla_back.sv]
// ============================================================================
// vdla_back
// Entry store with clearing pass, read-modify-write sequencer and read-out.
// ============================================================================
`default_nettype none

module vdla_back #(
    parameter int ENTRIES = 40960,
    parameter int AW      = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    output logic                 busy_clear,
    input  wire                  q_valid,
    output logic                 q_pop,
    input  wire                  q_rd,
    input  wire                  q_zero,
    input  wire                  q_two,
    input  wire [AW-1:0]         q_addr_a,
    input  wire [AW-1:0]         q_addr_b,
    input  wire [31:0]           q_e,
    input  wire [31:0]           q_l,
    output logic                 rd_valid,
    input  wire                  rd_ready,
    output vdla_pkg::rd_item_t   rd_item
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WRA  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_WRB  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [127:0] mem [ENTRIES];
    logic [127:0] rdata_reg;
    logic [2:0]   st_reg, st_next;
    logic [AW-1:0] clr_reg, addr;
    logic         we;
    logic [127:0] wdata;
    logic         mem_re;
    logic [48:0]  se, sl;
    logic [47:0]  ne, nl;
    logic [31:0]  nn;
    vdla_pkg::rd_item_t rd_reg;
    logic         rdv_reg;

    assign busy_clear = (st_reg == S_CLR);

    // Saturating update of the fetched entry
    always_comb
    begin
        se = {1'b0, rdata_reg[127:80]} + {17'd0, q_e};
        sl = {1'b0, rdata_reg[79:32]} + {17'd0, q_l};
        ne = se[48] ? vdla_pkg::MAX48 : se[47:0];
        nl = sl[48] ? vdla_pkg::MAX48 : sl[47:0];
        nn = (rdata_reg[31:0] == vdla_pkg::MAX32) ? rdata_reg[31:0]
                                                  : rdata_reg[31:0] + 32'd1;
    end

    // Sequence memory operations
    always_comb
    begin
        st_next = st_reg;
        we      = 1'b0;
        mem_re  = 1'b0;
        addr    = q_addr_a;
        wdata   = {ne, nl, nn};
        q_pop   = 1'b0;
        case (st_reg)
            S_CLR:
            begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = '0;
                if (clr_reg == AW'(ENTRIES - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_rd && q_zero)
                        st_next = S_OUT;
                    else
                    begin
                        mem_re  = 1'b1;
                        st_next = q_rd ? S_OUT : S_WRA;
                    end
                end
            end
            S_WRA:
            begin
                we = 1'b1;
                if (q_two)
                    st_next = S_RDB;
                else
                begin
                    q_pop   = 1'b1;
                    st_next = S_IDLE;
                end
            end
            S_RDB:
            begin
                mem_re  = 1'b1;
                addr    = q_addr_b;
                st_next = S_WRB;
            end
            S_WRB:
            begin
                we      = 1'b1;
                addr    = q_addr_b;
                q_pop   = 1'b1;
                st_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!rdv_reg || rd_ready)
                begin
                    q_pop   = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_CLR)
                clr_reg <= clr_reg + AW'(1);
            if (st_reg == S_OUT && q_pop)
                rdv_reg <= 1'b1;
            else if (rd_ready)
                rdv_reg <= 1'b0;
        end
    end

    // Store with registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[addr];
    end

    // Hold the read-out item
    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && q_pop)
        begin
            rd_reg.zero    <= q_zero;
            rd_reg.energy  <= q_zero ? 48'd0 : rdata_reg[127:80];
            rd_reg.let_sum <= q_zero ? 48'd0 : rdata_reg[79:32];
            rd_reg.events  <= q_zero ? 32'd0 : rdata_reg[31:0];
        end
    end

    assign rd_valid = rdv_reg;
    assign rd_item  = rd_reg;

endmodule

`default_nettype wire

[hw/rtl/vdla_math.sv]
// ============================================================================
// vdla_math
// Dose-averaged LET (serial divider) and dose (split multiply, then /1000
// by reciprocal multiplication in 11-bit chunks).
// ============================================================================
`default_nettype none

module vdla_math (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [31:0]           factor,
    input  wire                  rd_valid,
    output logic                 rd_ready,
    input  wire vdla_pkg::rd_item_t rd_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output vdla_pkg::out_item_t  out_item
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;
    localparam logic [1:0] M_OUT  = 2'd3;

    // ceil(2^52 / 1000): exact floor(x / 1000) for any x below 2^42
    localparam logic [43:0] DOSE_RECIP = 44'(((64'd1 << 52) / 64'd1000) + 64'd1);
    // Scaled products at or above this saturate the dose
    localparam logic [63:0] DOSE_SAT   = 64'd1000 << 32;

    logic [1:0]  st_reg;
    logic [6:0]  cnt_reg;
    logic [47:0] e_reg, l_reg;
    logic [31:0] n_reg, f_reg;
    logic        letz_reg;
    // LET divider: 64-bit dividend shifted out, 49-bit remainder
    logic [63:0] dq_reg;
    logic [48:0] dr_reg;
    // Dose: 64-bit scaled product, then multiply by the reciprocal of 1000
    logic [63:0] pa_reg, pb_reg;
    logic [41:0] dx_reg;
    logic        dsat_reg;
    logic [84:0] pacc_reg;
    logic [10:0] mchunk;
    logic [49:0] dtr;
    logic [63:0] psum;

    assign rd_ready  = (st_reg == M_IDLE);
    assign out_valid = (st_reg == M_OUT);
    assign dtr = {dr_reg, dq_reg[63]} - {2'b0, e_reg};
    assign psum = pa_reg + {16'd0, pb_reg[63:16]};

    // Pick the reciprocal chunk, most significant first
    always_comb
    begin
        case (cnt_reg)
            7'd1:    mchunk = DOSE_RECIP[43:33];
            7'd2:    mchunk = DOSE_RECIP[32:22];
            7'd3:    mchunk = DOSE_RECIP[21:11];
            default: mchunk = DOSE_RECIP[10:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= M_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            case (st_reg)
                M_IDLE:
                    if (rd_valid)
                        st_reg <= M_MUL;
                M_MUL:
                begin
                    st_reg  <= M_DIV;
                    cnt_reg <= '0;
                end
                M_DIV:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                        st_reg <= M_OUT;
                end
                M_OUT:
                    if (out_ready)
                        st_reg <= M_IDLE;
                default:
                    st_reg <= M_IDLE;
            endcase
        end
    end

    // Datapath: capture, multiply, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (st_reg)
            M_IDLE:
            begin
                e_reg    <= rd_item.energy;
                l_reg    <= rd_item.let_sum;
                n_reg    <= rd_item.events;
                f_reg    <= factor;
                letz_reg <= (rd_item.events <= 32'd1) || (rd_item.energy == 48'd0);
            end
            M_MUL:
            begin
                pa_reg <= {16'd0, e_reg} * {48'd0, f_reg[31:16]};
                pb_reg <= {16'd0, e_reg} * {48'd0, f_reg[15:0]};
                dq_reg <= {l_reg, 16'd0};
                dr_reg <= '0;
            end
            M_DIV:
            begin
                if (cnt_reg == 7'd0)
                begin
                    dsat_reg <= (psum >= DOSE_SAT);
                    dx_reg   <= psum[41:0];
                    pacc_reg <= '0;
                end
                else if (cnt_reg < 7'd5)
                    pacc_reg <= {pacc_reg[73:0], 11'd0} + 85'(dx_reg) * 85'(mchunk);
                if (cnt_reg < 7'd64 && !letz_reg)
                begin
                    if (dtr[49])
                    begin
                        dr_reg <= {dr_reg[47:0], dq_reg[63]};
                        dq_reg <= {dq_reg[62:0], 1'b0};
                    end
                    else
                    begin
                        dr_reg <= dtr[48:0];
                        dq_reg <= {dq_reg[62:0], 1'b1};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Saturate and form the result
    always_comb
    begin
        out_item.energy_total = e_reg;
        out_item.let_total    = l_reg;
        out_item.event_total  = n_reg;
        if (letz_reg)
            out_item.let_dose_averaged = '0;
        else if (dq_reg[63:32] != 32'd0)
            out_item.let_dose_averaged = vdla_pkg::MAX32;
        else
            out_item.let_dose_averaged = dq_reg[31:0];
        if (f_reg == 32'd0)
            out_item.dose_value = '0;
        else if (dsat_reg)
            out_item.dose_value = vdla_pkg::MAX32;
        else
            out_item.dose_value = pacc_reg[83:52];
    end

endmodule

`default_nettype wire

[hw/rtl/voxel_dose_let_accumulator_unit.sv]
// ============================================================================
// voxel_dose_let_accumulator_unit
// Per-voxel, per-class energy / LET / event accumulator with read-out math.
// ============================================================================
//  channel   handshake          payload
//  input     push / full        in_item  (vdla_pkg::in_item_t)
//  result    pop / empty        out_item (vdla_pkg::out_item_t)
//  config    cfg_valid/ready    cfg_data (mev_to_gray_factor)
//
//  Deposit: one read and one write per entry update on one store port; a
//  deposit with a class entry repeats the read and write for that entry.
//  Read: the result comes from the 64-step serial LET divider. After reset a
//  clearing pass writes all ENTRIES rows, one per cycle, with full held high.
//  A held result stalls the back end.
// ============================================================================
`default_nettype none

module voxel_dose_let_accumulator_unit #(
    parameter int VOXEL_COUNT = vdla_pkg::VOXEL_COUNT_DEF,
    parameter int CLASS_COUNT = vdla_pkg::CLASS_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire vdla_pkg::in_item_t in_item,
    output logic                 empty,
    input  wire                  pop,
    output vdla_pkg::out_item_t  out_item,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [31:0]           cfg_data
);

    localparam int ENTRIES = VOXEL_COUNT * CLASS_COUNT;
    localparam int AW      = $clog2(ENTRIES);

    logic [31:0] factor_reg;
    logic        q_valid, q_pop, q_rd, q_zero, q_two, front_full, busy_clear;
    logic [AW-1:0] q_addr_a, q_addr_b;
    logic [31:0] q_e, q_l;
    logic        rd_valid, rd_ready, out_valid;
    vdla_pkg::rd_item_t rd_item;

    assign cfg_ready = 1'b1;
    assign full      = front_full || busy_clear;
    assign empty     = !out_valid;

    // Hold the conversion factor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= '0;
        else if (cfg_valid)
            factor_reg <= cfg_data;
    end

    vdla_front #(.VOXEL_COUNT(VOXEL_COUNT), .CLASS_COUNT(CLASS_COUNT), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .push(push && !busy_clear), .full(front_full), .in_item(in_item),
        .q_valid(q_valid), .q_pop(q_pop), .q_rd(q_rd), .q_zero(q_zero),
        .q_two(q_two), .q_addr_a(q_addr_a), .q_addr_b(q_addr_b),
        .q_e(q_e), .q_l(q_l)
    );

    vdla_back #(.ENTRIES(ENTRIES), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .busy_clear(busy_clear),
        .q_valid(q_valid), .q_pop(q_pop), .q_rd(q_rd), .q_zero(q_zero),
        .q_two(q_two), .q_addr_a(q_addr_a), .q_addr_b(q_addr_b),
        .q_e(q_e), .q_l(q_l),
        .rd_valid(rd_valid), .rd_ready(rd_ready), .rd_item(rd_item)
    );

    vdla_math u_math (
        .clk(clk), .rst_n(rst_n), .factor(factor_reg),
        .rd_valid(rd_valid), .rd_ready(rd_ready), .rd_item(rd_item),
        .out_valid(out_valid), .out_ready(pop), .out_item(out_item)
    );

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking testbench for the voxel dose / LET accumulator.
// A scoreboard class keeps its own copy of the per-entry energy, LET and
// event sums and of the conversion factor. It predicts each read result and
// compares it field by field with what the block returns. Directed items
// cover the field extremes and the class corner cases. Random phases under
// several factors follow, with random idling on both queue sides.
// ============================================================================
`default_nettype none

module tb_top;

    localparam int VOXELS      = vdla_pkg::VOXEL_COUNT_DEF;
    localparam int CLASSES     = vdla_pkg::CLASS_COUNT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_ITEMS = 280;

    // Scoreboard: mirrors the accumulator stores and checks read results
    class dose_scoreboard;
        logic [47:0] energy_acc[int];
        logic [47:0] let_acc[int];
        logic [31:0] event_acc[int];
        logic [31:0] gray_factor;
        vdla_pkg::out_item_t expected_reads[$];
        int          errors;

        function new();
            gray_factor = '0;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? vdla_pkg::MAX48 : s[47:0];
        endfunction

        function void touch(int entry);
            if (!energy_acc.exists(entry))
            begin
                energy_acc[entry] = '0;
                let_acc[entry]    = '0;
                event_acc[entry]  = '0;
            end
        endfunction

        function void add_deposit(int entry, logic [31:0] e, logic [31:0] l);
            touch(entry);
            energy_acc[entry] = sat_add(energy_acc[entry], {16'h0, e});
            let_acc[entry]    = sat_add(let_acc[entry], {16'h0, l});
            if (event_acc[entry] != vdla_pkg::MAX32)
                event_acc[entry] = event_acc[entry] + 1;
        endfunction

        // Update the stores for a deposit, or queue the result of a read
        function void note_input(vdla_pkg::in_item_t it);
            int          cls;
            int          slot;
            int          base;
            int          entry;
            logic [63:0] num;
            logic [63:0] quo;
            logic [127:0] prod;
            vdla_pkg::out_item_t res;
            cls  = int'($signed(it.particle_class));
            slot = cls + 1;
            base = int'(it.voxel_index) * CLASSES;
            if (it.cmd == vdla_pkg::CMD_DEPOSIT)
            begin
                if (int'(it.voxel_index) >= VOXELS || it.energy_deposit == 0 ||
                    it.let_weight == 0)
                    return;
                add_deposit(base + 1, it.energy_deposit, it.let_weight);
                if (slot >= 0 && slot < CLASSES && slot != 1)
                    add_deposit(base + slot, it.energy_deposit, it.let_weight);
                return;
            end
            res = '0;
            if (int'(it.voxel_index) < VOXELS && slot >= 0 && slot < CLASSES)
            begin
                entry = base + slot;
                touch(entry);
                res.energy_total = energy_acc[entry];
                res.let_total    = let_acc[entry];
                res.event_total  = event_acc[entry];
                if (event_acc[entry] > 1 && energy_acc[entry] != 0)
                begin
                    num = {let_acc[entry], 16'h0};
                    quo = num / {16'h0, energy_acc[entry]};
                    res.let_dose_averaged = (quo > 64'(vdla_pkg::MAX32)) ? vdla_pkg::MAX32
                                                                          : quo[31:0];
                end
                if (gray_factor != 0)
                begin
                    prod = (128'(energy_acc[entry]) * 128'(gray_factor)) / 128'd65536000;
                    res.dose_value = (prod > 128'(vdla_pkg::MAX32)) ? vdla_pkg::MAX32
                                                                     : prod[31:0];
                end
            end
            expected_reads.push_back(res);
        endfunction

        task check_result(vdla_pkg::out_item_t got);
            vdla_pkg::out_item_t exp_item;
            if (expected_reads.size() == 0)
            begin
                report("result with no read pending");
                return;
            end
            exp_item = expected_reads.pop_front();
            if (got.energy_total !== exp_item.energy_total)
                report($sformatf("energy_total %h, want %h",
                                 got.energy_total, exp_item.energy_total));
            if (got.let_total !== exp_item.let_total)
                report($sformatf("let_total %h, want %h",
                                 got.let_total, exp_item.let_total));
            if (got.let_dose_averaged !== exp_item.let_dose_averaged)
                report($sformatf("let_dose_averaged %h, want %h",
                                 got.let_dose_averaged, exp_item.let_dose_averaged));
            if (got.event_total !== exp_item.event_total)
                report($sformatf("event_total %h, want %h",
                                 got.event_total, exp_item.event_total));
            if (got.dose_value !== exp_item.dose_value)
                report($sformatf("dose_value %h, want %h",
                                 got.dose_value, exp_item.dose_value));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    vdla_pkg::in_item_t  in_item;
    logic        empty;
    logic        pop;
    vdla_pkg::out_item_t out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    dose_scoreboard dose_sb;
    int             idle_pct;
    int             cycle_count;

    voxel_dose_let_accumulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock and reset
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: check each transfer, pop at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                dose_sb.check_result(out_item);
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one item, idling at random first; note it on transfer
    task send_item(vdla_pkg::in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        dose_sb.note_input(it);
    endtask

    // Hold until all reads are back and the back end has settled
    task wait_quiet();
        push <= 1'b0;
        @(posedge clk);
        while (dose_sb.expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task write_factor(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dose_sb.gray_factor = value;
    endtask

    function vdla_pkg::in_item_t make_item(logic cmd, int vox, int cls, logic [31:0] e,
                                           logic [31:0] l);
        vdla_pkg::in_item_t it;
        it.cmd            = cmd;
        it.voxel_index    = 12'(vox);
        it.particle_class = 5'(cls);
        it.energy_deposit = e;
        it.let_weight     = l;
        return it;
    endfunction

    function logic [31:0] rand_amount();
        case ($urandom_range(9))
            0:       return '0;
            1:       return vdla_pkg::MAX32;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    // Mostly a small voxel pool and legal classes, so reads hit live entries
    function vdla_pkg::in_item_t rand_item();
        int vox;
        int cls;
        vox = ($urandom_range(9) == 0) ? $urandom_range(VOXELS - 1) : $urandom_range(5);
        cls = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(9) - 1;
        return make_item(($urandom_range(99) < 40) ? vdla_pkg::CMD_READ
                                                   : vdla_pkg::CMD_DEPOSIT,
                         vox, cls, rand_amount(), rand_amount());
    endfunction

    task run_phase(logic [31:0] factor, int quiet_stretch);
        write_factor(factor);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            idle_pct = (quiet_stretch != 0 && i >= 40 && i < 200) ? 0 : 30;
            send_item(rand_item());
        end
        wait_quiet();
    endtask

    initial
    begin
        dose_sb  = new();
        idle_pct = 30;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: class corners, zero and max amounts, ratio saturation
        write_factor(32'h0001_0000);
        send_item(make_item(vdla_pkg::CMD_READ, 0, 0, '0, '0));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 0, 32'h0001_0000, 32'h0002_0000));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, -1, 32'h0003_0000, 32'h0001_0000));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 8, vdla_pkg::MAX32, vdla_pkg::MAX32));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 9, 32'h10, 32'h20));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 15, 32'h5, 32'h7));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, -16, 32'h9, 32'h3));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 3, '0, 32'h100));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, 0, 3, 32'h100, '0));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, VOXELS - 1, 2, 32'h1, vdla_pkg::MAX32));
        send_item(make_item(vdla_pkg::CMD_DEPOSIT, VOXELS - 1, 2, 32'h1, vdla_pkg::MAX32));
        send_item(make_item(vdla_pkg::CMD_READ, 0, 0, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, 0, -1, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, 0, 8, vdla_pkg::MAX32, vdla_pkg::MAX32));
        send_item(make_item(vdla_pkg::CMD_READ, 0, 9, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, 0, 15, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, 0, -16, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, 0, 3, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, VOXELS - 1, 2, '0, '0));
        send_item(make_item(vdla_pkg::CMD_READ, VOXELS - 1, 0, '0, '0));
        wait_quiet();

        // Random phases across the factor range
        run_phase(32'h0000_0000, 0);
        run_phase(32'hFFFF_FFFF, 1);
        run_phase($urandom, 0);
        run_phase(32'h0000_0001, 0);
        run_phase(32'h03E8_0000, 0);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (dose_sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
